[hdl/fpes_pkg.sv]
// Shared types and constants for the flash program and erase sequencer
`timescale 1ns / 1ps

package fpes_pkg;

  // width of the linear flash byte address
  localparam int ROM_ADDRESS_BITS = 19;

  // request modes
  localparam logic [1:0] MODE_PROGRAM = 2'd0;
  localparam logic [1:0] MODE_ERASE   = 2'd1;
  localparam logic [1:0] MODE_STATUS  = 2'd2;

  // bus operation kinds
  localparam logic [1:0] OP_BANK  = 2'd0;
  localparam logic [1:0] OP_WRITE = 2'd1;
  localparam logic [1:0] OP_READ  = 2'd2;
  localparam logic [1:0] OP_DONE  = 2'd3;

  // bus addresses and command bytes
  localparam logic [15:0] ADDR_BANK_REG = 16'h2100;
  localparam logic [15:0] ADDR_UNLOCK_1 = 16'h5555;
  localparam logic [15:0] ADDR_UNLOCK_2 = 16'h2AAA;
  localparam logic [7:0]  CMD_UNLOCK_1  = 8'hAA;
  localparam logic [7:0]  CMD_UNLOCK_2  = 8'h55;
  localparam logic [7:0]  CMD_PROGRAM   = 8'hA0;
  localparam logic [7:0]  CMD_ERASE     = 8'h80;
  localparam logic [7:0]  CMD_CHIP      = 8'h10;
  localparam logic [7:0]  CMD_BANK_ONE  = 8'h01;

  // status bits
  localparam int DQ7 = 7;
  localparam int DQ5 = 5;

  // algorithm register values
  localparam logic ALG_COMMAND    = 1'b0;
  localparam logic ALG_DATA_VALID = 1'b1;

  typedef struct packed {
    logic [1:0]                  mode;
    logic [ROM_ADDRESS_BITS-1:0] rom_address;
    logic [7:0]                  write_byte;
    logic [7:0]                  status_byte;
  } in_t;

  typedef struct packed {
    logic [1:0]  op_kind;
    logic [15:0] bus_address;
    logic [7:0]  bus_data;
    logic        passed;
    logic        last;
  } out_t;

endpackage

[hdl/flash_program_erase_sequencer.sv]
// Flash program and erase sequencer: request decode, burst emitter and status judgement
`timescale 1ns / 1ps

//  channel | direction | handshake              | payload
//  in      | input     | in_valid / in_ready    | fpes_pkg::in_t  (mode, address, bytes)
//  out     | output    | out_valid / out_ready  | fpes_pkg::out_t (one bus operation)
//  cfg     | input     | cfg_valid / cfg_ready  | algorithm_select, 1 bit
//
//  A program or erase request is decoded in the cycle it is accepted and held in a
//  burst register; the emitter then loads one bus operation per cycle into the output
//  register unless it is stalled: seven for a program (three in data-valid mode) or
//  an erase, one for a status. The next request is taken in the cycle the final
//  operation of a burst is loaded; requests that cause no operation load no burst.
//  Reset is synchronous and leaves the sequencer idle; a stall holds burst and input.
module flash_program_erase_sequencer (
  input  logic           clk,
  input  logic           rst,
  input  logic           in_valid,
  output logic           in_ready,
  input  fpes_pkg::in_t  in_data,
  output logic           out_valid,
  input  logic           out_ready,
  output fpes_pkg::out_t out_data,
  input  logic           cfg_valid,
  output logic           cfg_ready,
  input  logic           cfg_data
);
  import fpes_pkg::*;

  typedef enum logic [3:0] {
    PH_IDLE    = 4'b0001,
    PH_PROG    = 4'b0010,
    PH_RECHECK = 4'b0100,
    PH_ERASE   = 4'b1000
  } phase_t;

  typedef enum logic [2:0] {
    JOB_PROG   = 3'b001,
    JOB_ERASE  = 3'b010,
    JOB_SINGLE = 3'b100
  } job_kind_t;

  localparam logic [2:0] STEP_FIRST  = 3'd0;
  localparam logic [2:0] STEP_TARGET = 3'd4;
  localparam logic [2:0] STEP_FINAL  = 3'd6;

  // sequencer state
  phase_t      phase, phase_next;
  logic [7:0]  expected_byte, expected_next;
  logic [15:0] poll_address, poll_next;
  logic        algorithm_select;

  // burst register
  logic        job_valid;
  job_kind_t   job_kind;
  logic [2:0]  job_step;
  logic [15:0] job_addr;
  logic [7:0]  job_bank;
  logic [7:0]  job_data;
  logic [1:0]  job_op;
  logic        job_pass;
  logic        job_end;

  // decode of the incoming request
  logic        dec_valid;
  job_kind_t   dec_kind;
  logic [2:0]  dec_step;
  logic [15:0] dec_addr;
  logic [7:0]  dec_bank;
  logic [1:0]  dec_op;
  logic        dec_pass;

  logic [ROM_ADDRESS_BITS-1:0] addr_masked;
  logic [ROM_ADDRESS_BITS+7:0] addr_wide;
  logic [15:0]                 target_addr;
  logic [7:0]                  target_bank;

  logic  accept;
  logic  load;
  out_t  emit;

  // configuration port is always open
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      algorithm_select <= ALG_COMMAND;
    end else if (cfg_valid && cfg_ready) begin
      algorithm_select <= cfg_data;
    end
  end

  // handshake
  assign job_end  = (job_kind == JOB_SINGLE) || (job_step == STEP_FINAL);
  assign load     = job_valid && (!out_valid || out_ready);
  assign in_ready = !job_valid || (load && job_end);
  assign accept   = in_valid && in_ready;

  // address mapping onto bank register and bus window
  assign addr_masked = in_data.rom_address;
  assign addr_wide   = {8'd0, addr_masked};
  assign target_bank = addr_wide[21:14];
  assign target_addr = {1'b0, |addr_masked[ROM_ADDRESS_BITS-1:14], addr_masked[13:0]};

  // request decode and status judgement
  always_comb begin
    dec_valid     = 1'b0;
    dec_kind      = JOB_SINGLE;
    dec_step      = STEP_FIRST;
    dec_addr      = poll_address;
    dec_bank      = target_bank;
    dec_op        = OP_DONE;
    dec_pass      = 1'b0;
    phase_next    = phase;
    expected_next = expected_byte;
    poll_next     = poll_address;
    case (in_data.mode)
      MODE_PROGRAM: begin
        if (phase == PH_IDLE) begin
          dec_valid     = 1'b1;
          dec_kind      = JOB_PROG;
          dec_step      = (algorithm_select == ALG_COMMAND) ? STEP_FIRST : STEP_TARGET;
          dec_addr      = target_addr;
          poll_next     = target_addr;
          expected_next = in_data.write_byte;
          phase_next    = PH_PROG;
        end
      end
      MODE_ERASE: begin
        if (phase == PH_IDLE) begin
          dec_valid  = 1'b1;
          dec_kind   = JOB_ERASE;
          dec_addr   = 16'd0;
          poll_next  = 16'd0;
          phase_next = PH_ERASE;
        end
      end
      MODE_STATUS: begin
        case (phase)
          PH_PROG: begin
            dec_valid = 1'b1;
            if (in_data.status_byte == expected_byte) begin
              dec_op     = OP_DONE;
              dec_pass   = 1'b1;
              phase_next = PH_IDLE;
            end else begin
              dec_op = OP_READ;
              if (algorithm_select == ALG_COMMAND && in_data.status_byte[DQ5]) begin
                phase_next = PH_RECHECK;
              end
            end
          end
          PH_RECHECK: begin
            dec_valid  = 1'b1;
            dec_op     = OP_DONE;
            dec_pass   = (in_data.status_byte == expected_byte);
            phase_next = PH_IDLE;
          end
          PH_ERASE: begin
            dec_valid = 1'b1;
            if (!in_data.status_byte[DQ7] && !in_data.status_byte[DQ5]) begin
              dec_op = OP_READ;
            end else begin
              dec_op     = OP_DONE;
              dec_pass   = in_data.status_byte[DQ7] && in_data.status_byte[DQ5];
              phase_next = PH_IDLE;
            end
          end
          default: begin
            dec_valid = 1'b0;
          end
        endcase
      end
      default: begin
        dec_valid = 1'b0;
      end
    endcase
  end

  // sequencer state update on each accepted request
  always_ff @(posedge clk) begin
    if (rst) begin
      phase         <= PH_IDLE;
      expected_byte <= 8'd0;
      poll_address  <= 16'd0;
    end else if (accept) begin
      phase         <= phase_next;
      expected_byte <= expected_next;
      poll_address  <= poll_next;
    end
  end

  // burst register
  always_ff @(posedge clk) begin
    if (rst) begin
      job_valid <= 1'b0;
    end else if (accept && dec_valid) begin
      job_valid <= 1'b1;
    end else if (load && job_end) begin
      job_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (accept && dec_valid) begin
      job_kind <= dec_kind;
      job_step <= dec_step;
      job_addr <= dec_addr;
      job_bank <= dec_bank;
      job_data <= in_data.write_byte;
      job_op   <= dec_op;
      job_pass <= dec_pass;
    end else if (load) begin
      job_step <= job_step + 3'd1;
    end
  end

  // bus operation for the current burst step
  always_comb begin
    emit             = '0;
    emit.last        = job_end;
    case (job_kind)
      JOB_PROG: begin
        case (job_step)
          3'd0: begin
            emit.op_kind     = OP_BANK;
            emit.bus_address = ADDR_BANK_REG;
            emit.bus_data    = CMD_BANK_ONE;
          end
          3'd1: begin
            emit.op_kind     = OP_WRITE;
            emit.bus_address = ADDR_UNLOCK_1;
            emit.bus_data    = CMD_UNLOCK_1;
          end
          3'd2: begin
            emit.op_kind     = OP_WRITE;
            emit.bus_address = ADDR_UNLOCK_2;
            emit.bus_data    = CMD_UNLOCK_2;
          end
          3'd3: begin
            emit.op_kind     = OP_WRITE;
            emit.bus_address = ADDR_UNLOCK_1;
            emit.bus_data    = CMD_PROGRAM;
          end
          3'd4: begin
            emit.op_kind     = OP_BANK;
            emit.bus_address = ADDR_BANK_REG;
            emit.bus_data    = job_bank;
          end
          3'd5: begin
            emit.op_kind     = OP_WRITE;
            emit.bus_address = job_addr;
            emit.bus_data    = job_data;
          end
          default: begin
            emit.op_kind     = OP_READ;
            emit.bus_address = job_addr;
          end
        endcase
      end
      JOB_ERASE: begin
        case (job_step)
          3'd0, 3'd3: begin
            emit.op_kind     = OP_WRITE;
            emit.bus_address = ADDR_UNLOCK_1;
            emit.bus_data    = CMD_UNLOCK_1;
          end
          3'd1, 3'd4: begin
            emit.op_kind     = OP_WRITE;
            emit.bus_address = ADDR_UNLOCK_2;
            emit.bus_data    = CMD_UNLOCK_2;
          end
          3'd2: begin
            emit.op_kind     = OP_WRITE;
            emit.bus_address = ADDR_UNLOCK_1;
            emit.bus_data    = CMD_ERASE;
          end
          3'd5: begin
            emit.op_kind     = OP_WRITE;
            emit.bus_address = ADDR_UNLOCK_1;
            emit.bus_data    = CMD_CHIP;
          end
          default: begin
            emit.op_kind     = OP_READ;
            emit.bus_address = job_addr;
          end
        endcase
      end
      default: begin
        emit.op_kind     = job_op;
        emit.bus_address = (job_op == OP_READ) ? job_addr : 16'd0;
        emit.passed      = job_pass;
      end
    endcase
  end

  // output register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (load) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      out_data <= emit;
    end
  end

`ifndef SYNTHESIS
  // no new request while a burst still has operations to send
  assert property (@(posedge clk) disable iff (rst)
    (job_valid && !job_end) |-> !in_ready)
    else $error("request taken in the middle of a burst");

  // a finished report always closes its request
  assert property (@(posedge clk) disable iff (rst)
    (out_valid && out_data.op_kind == OP_DONE) |-> out_data.last)
    else $error("finished report without last");

  // pass flag only on a finished report
  assert property (@(posedge clk) disable iff (rst)
    (out_valid && out_data.passed) |-> (out_data.op_kind == OP_DONE))
    else $error("pass flag on a bus operation");

  // a program or erase burst is only started from idle
  assert property (@(posedge clk) disable iff (rst)
    (accept && dec_valid && dec_kind != JOB_SINGLE) |-> (phase == PH_IDLE))
    else $error("command burst started while polling");
`endif

endmodule

[dv/testbench.sv]
// Testbench for the flash program and erase sequencer, with a bus operation predictor
`timescale 1ns / 1ps

module testbench;
  import fpes_pkg::*;

  // request mode that the sequencer does not decode
  localparam logic [1:0] MODE_UNUSED = 2'd3;
  localparam int IDLE_PERCENT = 38;
  localparam int DRAIN_CYCLES = 12;
  localparam int RANDOM_ITEMS = 88;

  typedef enum logic [1:0] {ST_IDLE, ST_PROG_POLL, ST_RECHECK, ST_ERASE_POLL} seq_state_t;

  logic clk;
  logic rst;
  logic in_valid;
  logic in_ready;
  in_t  in_data;
  logic out_valid;
  logic out_ready;
  out_t out_data;
  logic cfg_valid;
  logic cfg_ready;
  logic cfg_data;

  // predicted sequencer state
  logic       alg_sel;
  seq_state_t seq_state;
  logic [7:0] target_byte;
  logic [15:0] poll_addr;

  out_t pending_ops[$];
  int   mismatches;
  int   items_sent;
  bit   no_idle;

  flash_program_erase_sequencer dut (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_data  (cfg_data)
  );

  // clock
  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // run limit
  initial begin
    #2000000;
    $display("flash_program_erase_sequencer: mismatch");
    $finish;
  end

  // queue one expected bus operation
  function automatic void push_op(logic [1:0] kind, logic [15:0] addr, logic [7:0] data,
                                  logic ok);
    out_t op;
    op.op_kind     = kind;
    op.bus_address = addr;
    op.bus_data    = data;
    op.passed      = ok;
    op.last        = 1'b0;
    pending_ops.push_back(op);
  endfunction

  // bus operations caused by one accepted request, and the state update
  function automatic void sequence_bus_ops(in_t req);
    int          n_before;
    out_t        tail;
    logic [7:0]  bank;
    logic [15:0] bus_addr;
    logic [7:0]  s;
    n_before = pending_ops.size();
    s = req.status_byte;
    case (req.mode)
      MODE_PROGRAM: begin
        if (seq_state == ST_IDLE) begin
          if (alg_sel == ALG_COMMAND) begin
            push_op(OP_BANK, ADDR_BANK_REG, CMD_BANK_ONE, 1'b0);
            push_op(OP_WRITE, ADDR_UNLOCK_1, CMD_UNLOCK_1, 1'b0);
            push_op(OP_WRITE, ADDR_UNLOCK_2, CMD_UNLOCK_2, 1'b0);
            push_op(OP_WRITE, ADDR_UNLOCK_1, CMD_PROGRAM, 1'b0);
          end
          bank = 8'(req.rom_address >> 14);
          bus_addr = 16'(req.rom_address[13:0]);
          if (req.rom_address > 'h3FFF) bus_addr = bus_addr + 16'h4000;
          push_op(OP_BANK, ADDR_BANK_REG, bank, 1'b0);
          push_op(OP_WRITE, bus_addr, req.write_byte, 1'b0);
          push_op(OP_READ, bus_addr, 8'h00, 1'b0);
          poll_addr   = bus_addr;
          target_byte = req.write_byte;
          seq_state   = ST_PROG_POLL;
        end
      end
      MODE_ERASE: begin
        if (seq_state == ST_IDLE) begin
          push_op(OP_WRITE, ADDR_UNLOCK_1, CMD_UNLOCK_1, 1'b0);
          push_op(OP_WRITE, ADDR_UNLOCK_2, CMD_UNLOCK_2, 1'b0);
          push_op(OP_WRITE, ADDR_UNLOCK_1, CMD_ERASE, 1'b0);
          push_op(OP_WRITE, ADDR_UNLOCK_1, CMD_UNLOCK_1, 1'b0);
          push_op(OP_WRITE, ADDR_UNLOCK_2, CMD_UNLOCK_2, 1'b0);
          push_op(OP_WRITE, ADDR_UNLOCK_1, CMD_CHIP, 1'b0);
          push_op(OP_READ, 16'h0000, 8'h00, 1'b0);
          poll_addr = 16'h0000;
          seq_state = ST_ERASE_POLL;
        end
      end
      MODE_STATUS: begin
        case (seq_state)
          ST_PROG_POLL: begin
            if (s == target_byte) begin
              push_op(OP_DONE, 16'h0000, 8'h00, 1'b1);
              seq_state = ST_IDLE;
            end else begin
              push_op(OP_READ, poll_addr, 8'h00, 1'b0);
              if (alg_sel == ALG_COMMAND && s[DQ5]) seq_state = ST_RECHECK;
            end
          end
          ST_RECHECK: begin
            push_op(OP_DONE, 16'h0000, 8'h00, s == target_byte);
            seq_state = ST_IDLE;
          end
          ST_ERASE_POLL: begin
            if (!s[DQ7] && !s[DQ5]) begin
              push_op(OP_READ, poll_addr, 8'h00, 1'b0);
            end else begin
              push_op(OP_DONE, 16'h0000, 8'h00, s[DQ7] && s[DQ5]);
              seq_state = ST_IDLE;
            end
          end
          default: ;
        endcase
      end
      default: ;
    endcase
    // mark the final operation of the burst
    if (pending_ops.size() > n_before) begin
      tail = pending_ops.pop_back();
      tail.last = 1'b1;
      pending_ops.push_back(tail);
    end
  endfunction

  function automatic void check_field(string field, int unsigned want, int unsigned got);
    if (want != got) begin
      $error("%s: expected 0x%0h, got 0x%0h", field, want, got);
      mismatches++;
    end
  endfunction

  // result checker
  always @(posedge clk) begin
    out_t want;
    if (!rst && out_valid && out_ready) begin
      if (pending_ops.size() == 0) begin
        $error("bus operation with none expected: 0x%0h", out_data);
        mismatches++;
      end else begin
        want = pending_ops.pop_front();
        check_field("op_kind", want.op_kind, out_data.op_kind);
        check_field("bus_address", want.bus_address, out_data.bus_address);
        check_field("bus_data", want.bus_data, out_data.bus_data);
        check_field("passed", want.passed, out_data.passed);
        check_field("last", want.last, out_data.last);
      end
    end
  end

  // output back-pressure
  initial begin
    out_ready = 1'b0;
    forever begin
      @(negedge clk);
      out_ready <= no_idle || ($urandom_range(99) >= IDLE_PERCENT);
    end
  end

  // request builders, unused fields random
  function automatic in_t make_req(logic [1:0] mode, logic [ROM_ADDRESS_BITS-1:0] addr,
                                   logic [7:0] wbyte, logic [7:0] sbyte);
    in_t req;
    req.mode        = mode;
    req.rom_address = addr;
    req.write_byte  = wbyte;
    req.status_byte = sbyte;
    return req;
  endfunction

  function automatic logic [ROM_ADDRESS_BITS-1:0] rand_addr();
    return ROM_ADDRESS_BITS'($urandom_range(0, (1 << ROM_ADDRESS_BITS) - 1));
  endfunction

  function automatic in_t program_req(logic [ROM_ADDRESS_BITS-1:0] addr, logic [7:0] wbyte);
    return make_req(MODE_PROGRAM, addr, wbyte, 8'($urandom));
  endfunction

  function automatic in_t erase_req();
    return make_req(MODE_ERASE, rand_addr(), 8'($urandom), 8'($urandom));
  endfunction

  function automatic in_t status_req(logic [7:0] sbyte);
    return make_req(MODE_STATUS, rand_addr(), 8'($urandom), sbyte);
  endfunction

  // send one request, idling first at random
  task automatic send_request(in_t req);
    while (!no_idle && $urandom_range(99) < IDLE_PERCENT) begin
      in_valid <= 1'b0;
      @(negedge clk);
    end
    in_valid <= 1'b1;
    in_data  <= req;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    @(negedge clk);
    sequence_bus_ops(req);
    items_sent++;
  endtask

  // wait until every expected operation is out and the sequencer has settled
  task automatic drain_results();
    in_valid <= 1'b0;
    while (pending_ops.size() != 0) @(negedge clk);
    repeat (DRAIN_CYCLES) @(negedge clk);
  endtask

  task automatic write_algorithm(logic value);
    drain_results();
    cfg_valid <= 1'b1;
    cfg_data  <= value;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    @(negedge clk);
    cfg_valid <= 1'b0;
    alg_sel = value;
  endtask

  // status and unused modes while idle cause nothing
  task automatic test_ignored_inputs();
    write_algorithm(ALG_COMMAND);
    send_request(status_req(8'hFF));
    send_request(make_req(MODE_UNUSED, '1, 8'hFF, 8'hFF));
    send_request(status_req(8'h00));
  endtask

  // unlock sequence programs with dq5 timeout and recheck
  task automatic test_command_program();
    send_request(program_req('0, 8'h00));
    send_request(status_req(8'h00));
    send_request(program_req('1, 8'hFF));
    send_request(erase_req());
    send_request(program_req(rand_addr(), 8'($urandom)));
    send_request(status_req(8'h00));
    send_request(status_req(8'h20));
    send_request(status_req(8'h7F));
    send_request(program_req('h3FFF, 8'hA5));
    send_request(status_req(8'h25));
    send_request(status_req(8'hA5));
    send_request(program_req('h4000, 8'h5A));
    send_request(status_req(8'h5A));
  endtask

  // chip erase: keep polling, then pass only with dq7 and dq5 both set
  task automatic test_chip_erase();
    send_request(erase_req());
    send_request(status_req(8'h00));
    send_request(status_req(8'h80));
    send_request(erase_req());
    send_request(status_req(8'h20));
    send_request(erase_req());
    send_request(status_req(8'hA0));
  endtask

  // data-valid mode: short program burst, dq5 ignored
  task automatic test_data_valid_poll();
    write_algorithm(ALG_DATA_VALID);
    send_request(program_req('h2ABCD, 8'h3C));
    send_request(status_req(8'h20));
    send_request(status_req(8'h3C));
    send_request(erase_req());
    send_request(status_req(8'hFF));
  endtask

  // register changes while a program poll is under way
  task automatic test_mode_change_in_poll();
    write_algorithm(ALG_COMMAND);
    send_request(program_req('h12345, 8'h81));
    write_algorithm(ALG_DATA_VALID);
    send_request(status_req(8'h20));
    write_algorithm(ALG_COMMAND);
    send_request(status_req(8'h21));
    send_request(status_req(8'h81));
  endtask

  // status byte that moves the current poll along, ending it after a few tries
  function automatic logic [7:0] poll_status(int polls);
    logic [7:0] s;
    s = 8'($urandom);
    case (seq_state)
      ST_PROG_POLL: begin
        if (polls >= 6 || $urandom_range(99) < 35) s = target_byte;
        else if ($urandom_range(99) < 30) s[DQ5] = 1'b1;
      end
      ST_RECHECK: begin
        if ($urandom_range(1) == 0) s = target_byte;
      end
      ST_ERASE_POLL: begin
        if (polls >= 6) s[DQ7] = 1'b1;
        else if ($urandom_range(99) < 50) begin
          s[DQ7] = 1'b0;
          s[DQ5] = 1'b0;
        end
      end
      default: ;
    endcase
    return s;
  endfunction

  function automatic logic [ROM_ADDRESS_BITS-1:0] program_addr();
    case ($urandom_range(7))
      0: return '0;
      1: return '1;
      2: return 'h3FFF;
      3: return 'h4000;
      default: return rand_addr();
    endcase
  endfunction

  // random command and poll sequences, with some noise
  task automatic test_random_sequences();
    int first;
    int polls;
    first = items_sent;
    polls = 0;
    while (items_sent - first < RANDOM_ITEMS) begin
      no_idle <= (items_sent - first >= 40) && (items_sent - first < 70);
      if ($urandom_range(99) < 10) write_algorithm(1'($urandom_range(1)));
      if (seq_state == ST_IDLE) begin
        polls = 0;
        case ($urandom_range(9))
          0: send_request(make_req($urandom_range(1) ? MODE_STATUS : MODE_UNUSED,
                                   rand_addr(), 8'($urandom), 8'($urandom)));
          1, 2, 3: send_request(erase_req());
          default: send_request(program_req(program_addr(), 8'($urandom)));
        endcase
      end else begin
        case ($urandom_range(9))
          0: send_request($urandom_range(1) ? erase_req()
                                            : program_req(rand_addr(), 8'($urandom)));
          default: begin
            send_request(status_req(poll_status(polls)));
            polls++;
          end
        endcase
      end
    end
  endtask

  // stimulus
  initial begin
    rst         = 1'b1;
    in_valid    = 1'b0;
    in_data     = '0;
    cfg_valid   = 1'b0;
    cfg_data    = 1'b0;
    alg_sel     = ALG_COMMAND;
    seq_state   = ST_IDLE;
    target_byte = 8'h00;
    poll_addr   = 16'h0000;
    mismatches  = 0;
    items_sent  = 0;
    no_idle     = 1'b0;
    repeat (8) @(negedge clk);
    rst <= 1'b0;
    test_ignored_inputs();
    test_command_program();
    test_chip_erase();
    test_data_valid_poll();
    test_mode_change_in_poll();
    test_random_sequences();
    drain_results();
    if (mismatches == 0 && pending_ops.size() == 0) begin
      $display("flash_program_erase_sequencer: match");
    end else begin
      $display("flash_program_erase_sequencer: mismatch");
    end
    $finish;
  end

endmodule

[files.f]
hdl/fpes_pkg.sv
hdl/flash_program_erase_sequencer.sv
dv/testbench.sv
